>>> rtl/sro_pkg.sv
// Shared types, widths and register indexes for the rectangle overlap test.
// No dependencies; imported by sat_rectangle_overlap_test.
package sro_pkg;

    // Coordinate width, Q12.4 signed at the default setting.
    localparam int COORD_WIDTH = 16;
    localparam int AXIS_WIDTH  = COORD_WIDTH + 1;
    localparam int PROD_WIDTH  = COORD_WIDTH + AXIS_WIDTH;
    localparam int PROJ_WIDTH  = PROD_WIDTH + 1;

    // Geometry: four corners per shape, two shapes, one axis per edge.
    localparam int NUM_CORNERS = 4;
    localparam int NUM_POINTS  = 2 * NUM_CORNERS;
    localparam int NUM_AXES    = 2 * NUM_CORNERS;

    // Configuration port.
    localparam int CFG_IDX_WIDTH = 4;

    // Clock edges from the accepting edge to the edge that raises the strobe.
    localparam int LATENCY = 5;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;
    typedef logic signed [AXIS_WIDTH-1:0]  t_axis;
    typedef logic signed [PROD_WIDTH-1:0]  t_prod;
    typedef logic signed [PROJ_WIDTH-1:0]  t_proj;
    typedef logic [CFG_IDX_WIDTH-1:0]      t_cfg_idx;

    // Register indexes of the zone corner coordinates.
    localparam t_cfg_idx REG_ZONE_X0 = t_cfg_idx'(0);
    localparam t_cfg_idx REG_ZONE_Z0 = t_cfg_idx'(1);
    localparam t_cfg_idx REG_ZONE_X1 = t_cfg_idx'(2);
    localparam t_cfg_idx REG_ZONE_Z1 = t_cfg_idx'(3);
    localparam t_cfg_idx REG_ZONE_X2 = t_cfg_idx'(4);
    localparam t_cfg_idx REG_ZONE_Z2 = t_cfg_idx'(5);
    localparam t_cfg_idx REG_ZONE_X3 = t_cfg_idx'(6);
    localparam t_cfg_idx REG_ZONE_Z3 = t_cfg_idx'(7);

    // Smallest of four projections.
    function automatic t_proj min4(t_proj a, t_proj b, t_proj c, t_proj d);
        t_proj ab;
        t_proj cd;
        ab = (a < b) ? a : b;
        cd = (c < d) ? c : d;
        return (ab < cd) ? ab : cd;
    endfunction

    // Largest of four projections.
    function automatic t_proj max4(t_proj a, t_proj b, t_proj c, t_proj d);
        t_proj ab;
        t_proj cd;
        ab = (a > b) ? a : b;
        cd = (c > d) ? c : d;
        return (ab > cd) ? ab : cd;
    endfunction

endpackage

>>> rtl/sat_rectangle_overlap_test.sv
// Throughput: one box per cycle; o_busy stays low, so start is taken in every cycle.
// o_valid and o_overlaps are registered through the stages: input, edge axes, products, projection sums,
// interval ends, result. The receiver cannot stall; each result is shown for one cycle.
// Reset (synchronous, active low) clears the pipeline valid bits and the zone corners to 0.
// Separating-axis overlap test of a configured zone quadrilateral against an input box.
// Depends on sro_pkg for widths, types, register indexes and min/max helpers.
module sat_rectangle_overlap_test (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    output logic                   o_busy,
    input  logic                   i_cfg_we,
    input  sro_pkg::t_cfg_idx      i_cfg_idx,
    input  sro_pkg::t_coord        i_cfg_data,
    input  sro_pkg::t_coord        i_box_x0,
    input  sro_pkg::t_coord        i_box_z0,
    input  sro_pkg::t_coord        i_box_x1,
    input  sro_pkg::t_coord        i_box_z1,
    input  sro_pkg::t_coord        i_box_x2,
    input  sro_pkg::t_coord        i_box_z2,
    input  sro_pkg::t_coord        i_box_x3,
    input  sro_pkg::t_coord        i_box_z3,
    output logic                   o_valid,
    output logic                   o_overlaps
);
    import sro_pkg::*;

    // Zone corners from configuration.
    t_coord r_zone_x [NUM_CORNERS];
    t_coord r_zone_z [NUM_CORNERS];

    // Input stage.
    logic   r_in_vld;
    t_coord r_box_x [NUM_CORNERS];
    t_coord r_box_z [NUM_CORNERS];

    // Axis stage.
    logic   r_ax_vld;
    t_axis  r_ax [NUM_AXES];
    t_axis  r_az [NUM_AXES];
    t_coord r_px [NUM_POINTS];
    t_coord r_pz [NUM_POINTS];

    // Product stage.
    logic   r_prod_vld;
    t_prod  r_mx [NUM_AXES][NUM_POINTS];
    t_prod  r_mz [NUM_AXES][NUM_POINTS];

    // Projection stage.
    logic   r_proj_vld;
    t_proj  r_proj [NUM_AXES][NUM_POINTS];

    // Interval stage: one interval per axis and shape.
    logic   r_ivl_vld;
    t_proj  r_lo [NUM_AXES][2];
    t_proj  r_hi [NUM_AXES][2];

    // Result stage.
    logic   r_valid;
    logic   r_overlaps;
    logic   n_overlaps;

    // Combined point list: zone corners first, then box corners.
    t_coord pt_x [NUM_POINTS];
    t_coord pt_z [NUM_POINTS];
    logic   sep  [NUM_AXES];

    // Every cycle can take a transfer.
    assign o_busy = 1'b0;

    // Configuration writes; indexes beyond the list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CORNERS; i++) begin
                r_zone_x[i] <= '0;
                r_zone_z[i] <= '0;
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_ZONE_X0: r_zone_x[0] <= i_cfg_data;
                REG_ZONE_Z0: r_zone_z[0] <= i_cfg_data;
                REG_ZONE_X1: r_zone_x[1] <= i_cfg_data;
                REG_ZONE_Z1: r_zone_z[1] <= i_cfg_data;
                REG_ZONE_X2: r_zone_x[2] <= i_cfg_data;
                REG_ZONE_Z2: r_zone_z[2] <= i_cfg_data;
                REG_ZONE_X3: r_zone_x[3] <= i_cfg_data;
                REG_ZONE_Z3: r_zone_z[3] <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Valid bits move down the pipeline with each transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld   <= 1'b0;
            r_ax_vld   <= 1'b0;
            r_prod_vld <= 1'b0;
            r_proj_vld <= 1'b0;
            r_ivl_vld  <= 1'b0;
            r_valid    <= 1'b0;
        end else begin
            r_in_vld   <= i_start;
            r_ax_vld   <= r_in_vld;
            r_prod_vld <= r_ax_vld;
            r_proj_vld <= r_prod_vld;
            r_ivl_vld  <= r_proj_vld;
            r_valid    <= r_ivl_vld;
        end
    end

    // Input register captures the box corners of an accepted transfer.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_box_x[0] <= i_box_x0;
            r_box_z[0] <= i_box_z0;
            r_box_x[1] <= i_box_x1;
            r_box_z[1] <= i_box_z1;
            r_box_x[2] <= i_box_x2;
            r_box_z[2] <= i_box_z2;
            r_box_x[3] <= i_box_x3;
            r_box_z[3] <= i_box_z3;
        end
    end

    // Gather both shapes into one point list.
    always_comb begin
        for (int i = 0; i < NUM_CORNERS; i++) begin
            pt_x[i]               = r_zone_x[i];
            pt_z[i]               = r_zone_z[i];
            pt_x[NUM_CORNERS + i] = r_box_x[i];
            pt_z[NUM_CORNERS + i] = r_box_z[i];
        end
    end

    // Edge normals (-dz, dx) for each edge from corner i to corner i+1 of each shape.
    always_ff @(posedge i_clk) begin
        for (int s = 0; s < 2; s++) begin
            for (int i = 0; i < NUM_CORNERS; i++) begin
                r_ax[s*NUM_CORNERS + i] <=
                    t_axis'(pt_z[s*NUM_CORNERS + i])
                    - t_axis'(pt_z[s*NUM_CORNERS + ((i + 1) % NUM_CORNERS)]);
                r_az[s*NUM_CORNERS + i] <=
                    t_axis'(pt_x[s*NUM_CORNERS + ((i + 1) % NUM_CORNERS)])
                    - t_axis'(pt_x[s*NUM_CORNERS + i]);
            end
        end
        for (int p = 0; p < NUM_POINTS; p++) begin
            r_px[p] <= pt_x[p];
            r_pz[p] <= pt_z[p];
        end
    end

    // One product pair per axis and point.
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NUM_AXES; k++) begin
            for (int p = 0; p < NUM_POINTS; p++) begin
                r_mx[k][p] <= t_prod'(r_px[p]) * t_prod'(r_ax[k]);
                r_mz[k][p] <= t_prod'(r_pz[p]) * t_prod'(r_az[k]);
            end
        end
    end

    // Projection of each point onto each axis; the sum is exact at this width.
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NUM_AXES; k++) begin
            for (int p = 0; p < NUM_POINTS; p++) begin
                r_proj[k][p] <= t_proj'(r_mx[k][p]) + t_proj'(r_mz[k][p]);
            end
        end
    end

    // Projection interval of each shape on each axis.
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NUM_AXES; k++) begin
            for (int s = 0; s < 2; s++) begin
                r_lo[k][s] <= min4(r_proj[k][s*NUM_CORNERS],     r_proj[k][s*NUM_CORNERS + 1],
                                   r_proj[k][s*NUM_CORNERS + 2], r_proj[k][s*NUM_CORNERS + 3]);
                r_hi[k][s] <= max4(r_proj[k][s*NUM_CORNERS],     r_proj[k][s*NUM_CORNERS + 1],
                                   r_proj[k][s*NUM_CORNERS + 2], r_proj[k][s*NUM_CORNERS + 3]);
            end
        end
    end

    // An axis separates when the intervals have a strict gap; touching counts as overlap.
    always_comb begin
        n_overlaps = 1'b1;
        for (int k = 0; k < NUM_AXES; k++) begin
            sep[k] = (r_hi[k][0] < r_lo[k][1]) || (r_hi[k][1] < r_lo[k][0]);
            if (sep[k]) begin
                n_overlaps = 1'b0;
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        r_overlaps <= n_overlaps;
    end

    assign o_valid    = r_valid;
    assign o_overlaps = r_overlaps;

    // Every accepted transfer yields its result strobe once it has passed every pipeline stage.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> ##(LATENCY + 1) o_valid)
        else $error("result strobe missing after accepted transfer");

    // A result strobe is never raised without a matching earlier transfer.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_start, LATENCY + 1))
        else $error("result strobe without an accepted transfer");

    // A zero-length edge gives a null axis whose intervals collapse to zero.
    for (genvar g = 0; g < NUM_AXES; g++) begin : g_null_axis
        a_null_axis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            (r_ax_vld && r_ax[g] == '0 && r_az[g] == '0) |->
            ##3 (r_lo[g][0] == '0 && r_hi[g][0] == '0 &&
                 r_lo[g][1] == '0 && r_hi[g][1] == '0))
            else $error("null axis produced a nonzero projection interval");
    end

endmodule
